FILE: rtl/core/mtlf_pkg.sv
// Shared types and constants for the move table LF step block.
package mtlf_pkg;

	localparam int RUNS_DEF     = 65536;
	localparam int LEN_BITS_DEF = 16;
	localparam int IDX_W        = 16;   // run number / table field width
	localparam int OFF_W        = 17;   // offset after adding the head offset
	localparam int NR_W         = 17;   // num_runs register width
	localparam int CNT_W        = 16;
	localparam int QUEUE_DEPTH  = 2;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;

	localparam logic [CNT_W-1:0] FF_LIMIT = 16'hFFFF;

	// item command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// register index decoded from paddr[2]
	localparam logic REG_NUM_RUNS = 1'b0;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DEST = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic             is_step;
		logic             in_range;   // run_index below table depth
		logic [IDX_W-1:0] run_index;
		logic [IDX_W-1:0] query_offset;
		logic [IDX_W-1:0] run_length;
		logic [IDX_W-1:0] head_offset;
		logic [IDX_W-1:0] dest_run;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] new_run;
		logic [OFF_W-1:0] new_offset;
		logic [CNT_W-1:0] forward_count;
		status_t          status;
	} res_t;

endpackage

FILE: rtl/core/mtlf_ram.sv
// Generic single-port RAM with registered read data.
module mtlf_ram #(
	parameter int W     = 48,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [W-1:0]             wdata,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: rtl/core/mtlf_fifo.sv
// Small register FIFO used for the item queue and the result queue.
module mtlf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: rtl/core/mtlf_front.sv
// Front end: takes items, tags command type and index range, queues them.
module mtlf_front import mtlf_pkg::*; #(
	parameter int RUNS = RUNS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             cmd,
	input  logic [IDX_W-1:0] run_index,
	input  logic [IDX_W-1:0] query_offset,
	input  logic [IDX_W-1:0] run_length,
	input  logic [IDX_W-1:0] head_offset,
	input  logic [IDX_W-1:0] dest_run,
	output cmd_t             q_cmd,
	output logic             q_vld,
	input  logic             q_pop
);

	cmd_t in_cmd;
	logic q_empty;

	always_comb begin
		in_cmd.is_step      = (cmd == CMD_STEP);
		in_cmd.in_range     = (int'(run_index) < RUNS);
		in_cmd.run_index    = run_index;
		in_cmd.query_offset = query_offset;
		in_cmd.run_length   = run_length;
		in_cmd.head_offset  = head_offset;
		in_cmd.dest_run     = dest_run;
	end

	mtlf_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_cmd),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_cmd),
		.empty  (q_empty)
	);

	assign q_vld = !q_empty;

endmodule

FILE: rtl/core/mtlf_back.sv
// Back end: run table, row writes, LF step walk and result queue.
module mtlf_back import mtlf_pkg::*; #(
	parameter int RUNS     = RUNS_DEF,
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [NR_W-1:0] r_eff,
	input  logic            cmd_vld,
	input  cmd_t            cmd,
	output logic            cmd_pop,
	output res_t            res,
	output logic            res_empty,
	input  logic            res_pop
);

	localparam int AW    = $clog2(RUNS);
	localparam int ROW_W = LEN_BITS + 2 * IDX_W;
	localparam int CMP_W = (LEN_BITS > OFF_W) ? LEN_BITS : OFF_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_HEAD = 4'b0010,
		S_WALK = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic             ram_en, ram_we;
	logic [AW-1:0]    ram_addr;
	logic [ROW_W-1:0] ram_wdata, ram_rdata;

	logic [LEN_BITS-1:0] rd_len;
	logic [IDX_W-1:0]    rd_head, rd_dest;

	logic [IDX_W-1:0] idx_q, start_q, qoff_q, idx_nxt;
	logic [OFF_W-1:0] off_q, off_head;
	logic             err_q;
	logic             dest_bad, more, fits, advance;
	logic [CNT_W-1:0] cnt;

	res_t res_d;
	logic res_push, res_full;

	assign rd_len  = ram_rdata[ROW_W-1 -: LEN_BITS];
	assign rd_head = ram_rdata[2*IDX_W-1 -: IDX_W];
	assign rd_dest = ram_rdata[IDX_W-1:0];

	assign off_head = OFF_W'(rd_head) + OFF_W'(qoff_q);
	assign dest_bad = ({1'b0, rd_dest} >= r_eff);
	assign idx_nxt  = idx_q + 1'b1;
	// the walk never passes the last loaded run
	assign more     = (({1'b0, idx_q} + NR_W'(1)) < r_eff);
	assign fits     = (CMP_W'(off_q) >= CMP_W'(rd_len));
	assign advance  = more && fits;
	assign cnt      = idx_q - start_q;

	always_comb begin
		state_d   = state_q;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = AW'(cmd.run_index);
		ram_wdata = {LEN_BITS'(cmd.run_length), cmd.head_offset, cmd.dest_run};
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_vld) begin
					cmd_pop = 1'b1;
					if (cmd.in_range) begin
						ram_en = 1'b1;
						ram_we = !cmd.is_step;
					end
					state_d = (cmd.is_step && cmd.in_range) ? S_HEAD : S_DONE;
				end
			end
			S_HEAD: begin
				if (dest_bad) begin
					state_d = S_DONE;
				end else begin
					ram_en   = 1'b1;
					ram_addr = AW'(rd_dest);
					state_d  = S_WALK;
				end
			end
			S_WALK: begin
				if (advance) begin
					ram_en   = 1'b1;
					ram_addr = AW'(idx_nxt);
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_vld) begin
			qoff_q  <= cmd.query_offset;
			idx_q   <= '0;
			start_q <= '0;
			off_q   <= '0;
			err_q   <= cmd.is_step && !cmd.in_range;
		end else if (state_q == S_HEAD) begin
			if (dest_bad) begin
				err_q <= 1'b1;
			end else begin
				idx_q   <= rd_dest;
				start_q <= rd_dest;
				off_q   <= off_head;
			end
		end else if (state_q == S_WALK && advance) begin
			off_q <= off_q - OFF_W'(rd_len);
			idx_q <= idx_nxt;
		end
	end

	always_comb begin
		res_d.new_run       = idx_q;
		res_d.new_offset    = off_q;
		res_d.forward_count = cnt;
		if (err_q) begin
			res_d.status = ST_DEST;
		end else if (cnt == FF_LIMIT) begin
			res_d.status = ST_OVF;
		end else begin
			res_d.status = ST_OK;
		end
	end

	mtlf_ram #(
		.W     (ROW_W),
		.DEPTH (RUNS)
	) u_run_table (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	mtlf_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_d),
		.full   (res_full),
		.pop    (res_pop),
		.rdata  (res),
		.empty  (res_empty)
	);

endmodule

FILE: rtl/core/move_table_lf_step.sv
// Move table LF step top level: config register, front queue and back end.
// A row write goes into the table and then queues its result; a step reads
//   its start row, then the destination row, then one row per run skipped.
// The back end takes a new item only once the last one's result is queued;
//   the single table port (one row read per walked run) sets the pace.
// Reset (arst_n low, asynchronous): queues empty, num_runs = 1; table rows
//   keep no reset value and must be written before they are read.
module move_table_lf_step import mtlf_pkg::*; #(
	parameter int RUNS     = RUNS_DEF,
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// item side
	input  logic              push,
	output logic              full,
	input  logic              cmd,
	input  logic [IDX_W-1:0]  run_index,
	input  logic [IDX_W-1:0]  query_offset,
	input  logic [IDX_W-1:0]  run_length,
	input  logic [IDX_W-1:0]  head_offset,
	input  logic [IDX_W-1:0]  dest_run,
	// result side
	output logic              empty,
	input  logic              pop,
	output logic [IDX_W-1:0]  new_run,
	output logic [OFF_W-1:0]  new_offset,
	output logic [CNT_W-1:0]  forward_count,
	output logic [1:0]        status,
	// config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [NR_W-1:0] num_runs_q;
	logic [NR_W-1:0] r_eff;
	logic            cfg_wr;

	cmd_t q_cmd;
	logic q_vld, q_pop;
	res_t res;

	// Config: a single register, num_runs, at byte address 0.
	// paddr[2] selects the register; the low byte-lane bits are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_runs_q <= NR_W'(1);
		end else if (cfg_wr && paddr[2] == REG_NUM_RUNS) begin
			num_runs_q <= pwdata[NR_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_NUM_RUNS) ? APB_DW'(num_runs_q) : '0;

	// Effective run count: num_runs clipped to the table depth.
	assign r_eff = (int'(num_runs_q) > RUNS) ? NR_W'(RUNS) : num_runs_q;

	// Front: accepts items, tags step/write and whether the index is inside
	// the table, and buffers up to two of them while the walk stalls; push waits once full.
	mtlf_front #(
		.RUNS (RUNS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.run_index    (run_index),
		.query_offset (query_offset),
		.run_length   (run_length),
		.head_offset  (head_offset),
		.dest_run     (dest_run),
		.q_cmd        (q_cmd),
		.q_vld        (q_vld),
		.q_pop        (q_pop)
	);

	// Back: owns the run table. Writes go straight in; a step reads the
	// start row, then one row per cycle until the offset fits or the last run is reached.
	mtlf_back #(
		.RUNS     (RUNS),
		.LEN_BITS (LEN_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.r_eff     (r_eff),
		.cmd_vld   (q_vld),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	// Result queue head drives the result ports directly.
	assign new_run       = res.new_run;
	assign new_offset    = res.new_offset;
	assign forward_count = res.forward_count;
	assign status        = res.status;

endmodule

FILE: rtl/core/mtlf_chk.sv
// Port-level checks for the move table LF step block, bound to the top level.
module mtlf_chk import mtlf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic [IDX_W-1:0] new_run,
	input logic [OFF_W-1:0] new_offset,
	input logic [CNT_W-1:0] forward_count,
	input logic [1:0]       status
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == ST_OK || status == ST_DEST || status == ST_OVF))
		else $error("result status code unused");

	a_dest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_DEST) |->
		(new_run == '0 && new_offset == '0 && forward_count == '0))
		else $error("range error result carries nonzero fields");

	a_ovf_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_OVF) |-> (forward_count == FF_LIMIT))
		else $error("overflow result without saturated count");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_OK) |-> (forward_count != FF_LIMIT))
		else $error("saturated count reported as ok");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result dropped without pop");

endmodule

bind move_table_lf_step mtlf_chk u_mtlf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.new_run       (new_run),
	.new_offset    (new_offset),
	.forward_count (forward_count),
	.status        (status)
);

FILE: dv/move_table_lf_step_check.sv
// Checker for the move table LF step block: watches both queues and the config port.
module move_table_lf_step_check import mtlf_pkg::*; #(
	parameter int RUNS     = RUNS_DEF,
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic              cmd,
	input  logic [IDX_W-1:0]  run_index,
	input  logic [IDX_W-1:0]  query_offset,
	input  logic [IDX_W-1:0]  run_length,
	input  logic [IDX_W-1:0]  head_offset,
	input  logic [IDX_W-1:0]  dest_run,
	input  logic              empty,
	input  logic              pop,
	input  logic [IDX_W-1:0]  new_run,
	input  logic [OFF_W-1:0]  new_offset,
	input  logic [CNT_W-1:0]  forward_count,
	input  logic [1:0]        status,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              pready,
	output int                mismatches,
	output int                pending,
	output int                checked,
	output int                saturated
);

	localparam logic [IDX_W-1:0] LEN_MASK = IDX_W'((64'd1 << LEN_BITS) - 64'd1);
	localparam int REPORT_MAX = 10;

	logic [IDX_W-1:0] row_len  [RUNS];
	logic [IDX_W-1:0] row_head [RUNS];
	logic [IDX_W-1:0] row_dest [RUNS];
	logic [NR_W-1:0]  runs_loaded = NR_W'(1);
	res_t             positions_due [$];
	res_t             due;
	int               errs = 0;
	int               done_cnt = 0;
	int               sat_cnt = 0;

	// position reached by one LF step from start_row at offset qoff
	function automatic res_t lf_move(int start_row, int qoff);
		res_t p;
		int   r, idx, first, off, skipped;
		p = '0;
		r = (runs_loaded > RUNS) ? RUNS : int'(runs_loaded);
		if (start_row >= RUNS) begin
			p.status = ST_DEST;
			return p;
		end
		idx = row_dest[start_row];
		if (idx >= r) begin
			p.status = ST_DEST;
			return p;
		end
		off = row_head[start_row] + qoff;
		first = idx;
		while (idx + 1 < r && off >= int'(row_len[idx])) begin
			off -= row_len[idx];
			idx++;
		end
		skipped = idx - first;
		p.new_run = IDX_W'(idx);
		p.new_offset = OFF_W'(off);
		if (skipped >= int'(FF_LIMIT)) begin
			p.forward_count = FF_LIMIT;
			p.status = ST_OVF;
		end else begin
			p.forward_count = CNT_W'(skipped);
		end
		return p;
	endfunction

	task automatic flag_mismatch(string what, int want, int got);
		errs++;
		if (errs <= REPORT_MAX) begin
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_loaded = NR_W'(1);
			positions_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_RUNS) begin
				runs_loaded = pwdata[NR_W-1:0];
			end
			if (pop && !empty) begin
				if (positions_due.size() == 0) begin
					flag_mismatch("result with none due (new_run)", -1, new_run);
				end else begin
					due = positions_due.pop_front();
					if (new_run !== due.new_run)
						flag_mismatch("new_run", due.new_run, new_run);
					if (new_offset !== due.new_offset)
						flag_mismatch("new_offset", due.new_offset, new_offset);
					if (forward_count !== due.forward_count)
						flag_mismatch("forward_count", due.forward_count, forward_count);
					if (status !== due.status)
						flag_mismatch("status", due.status, status);
					done_cnt++;
					if (due.status == ST_OVF) sat_cnt++;
				end
			end
			if (push && !full) begin
				if (cmd == CMD_STEP) begin
					positions_due.push_back(lf_move(run_index, query_offset));
				end else begin
					if (run_index < RUNS) begin
						row_len[run_index]  = run_length & LEN_MASK;
						row_head[run_index] = head_offset;
						row_dest[run_index] = dest_run;
					end
					positions_due.push_back('0);
				end
			end
			pending <= positions_due.size();
		end
		mismatches <= errs;
		checked <= done_cnt;
		saturated <= sat_cnt;
	end

endmodule

FILE: dv/move_table_lf_step_test.sv
// Testbench top for the move table LF step block: stimulus, reset, clock and verdict.
module move_table_lf_step_test;
	import mtlf_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;  // watchdog bound on the whole run
	localparam int HOLD_CYCLES = 400;        // long receiver stall, fills the block
	localparam int TAIL_CYCLES = 80;         // drain margin after the last result
	localparam int REGION_MAX  = 40;         // cap on rows loaded at the start of a phase

	logic              clk;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              cmd = CMD_WRITE;
	logic [IDX_W-1:0]  run_index = '0;
	logic [IDX_W-1:0]  query_offset = '0;
	logic [IDX_W-1:0]  run_length = '0;
	logic [IDX_W-1:0]  head_offset = '0;
	logic [IDX_W-1:0]  dest_run = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [IDX_W-1:0]  new_run;
	logic [OFF_W-1:0]  new_offset;
	logic [CNT_W-1:0]  forward_count;
	logic [1:0]        status;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                mismatches, pending, checked, saturated;

	// What the stimulus has loaded so far. Used only to keep every step away
	// from rows that were never written (their contents are undefined).
	logic [IDX_W-1:0] plan_len  [RUNS_DEF];
	logic [IDX_W-1:0] plan_head [RUNS_DEF];
	logic [IDX_W-1:0] plan_dest [RUNS_DEF];
	bit               plan_written [RUNS_DEF];
	int               far_rows [$];      // rows written outside the phase region
	int               runs_now = 1;      // num_runs as the block holds it
	bit               calm = 1'b0;       // no idling on either side while set
	bit               hold_req = 1'b0;   // asks the receiver for one long stall
	int               n_writes = 0, n_steps = 0, n_settings = 0;

	move_table_lf_step dut (.*);
	move_table_lf_step_check checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	// mostly back to back or short gaps, now and then a long one
	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// field value: mostly within span, with zero, all ones and full-width noise mixed in
	function automatic logic [IDX_W-1:0] pick_val(int span);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8) return '0;
		if (roll < 14) return '1;
		if (roll < 22) return IDX_W'($urandom);
		return IDX_W'($urandom_range(0, span));
	endfunction

	// destination: mostly a loaded row, sometimes out of range
	function automatic logic [IDX_W-1:0] pick_dest(int region, int runs);
		if ($urandom_range(0, 99) < 12) begin
			if (runs < RUNS_DEF) return IDX_W'($urandom_range(runs, RUNS_DEF - 1));
			return IDX_W'($urandom);
		end
		return IDX_W'($urandom_range(0, region - 1));
	endfunction

	// Offer one item, hold it until accepted. push stays high into the next
	// item when that one comes with no gap.
	task automatic put_item(logic c, int ri, logic [IDX_W-1:0] q, logic [IDX_W-1:0] len,
			logic [IDX_W-1:0] head, logic [IDX_W-1:0] dest);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		run_index <= IDX_W'(ri);
		query_offset <= q;
		run_length <= len;
		head_offset <= head;
		dest_run <= dest;
		do @(posedge clk); while (full);
		if (c == CMD_WRITE) begin
			plan_len[ri] = len;
			plan_head[ri] = head;
			plan_dest[ri] = dest;
			plan_written[ri] = 1'b1;
			n_writes++;
		end else begin
			n_steps++;
		end
	endtask

	task automatic load_row(int ri, logic [IDX_W-1:0] len, logic [IDX_W-1:0] head,
			logic [IDX_W-1:0] dest);
		put_item(CMD_WRITE, ri, IDX_W'($urandom), len, head, dest);
	endtask

	// unused row fields carry noise on a step
	task automatic lf_query(int ri, logic [IDX_W-1:0] q);
		put_item(CMD_STEP, ri, q, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
	endtask

	// num_runs changes only with the block drained
	task automatic set_runs(int v);
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_NUM_RUNS, 2'b00};
		pwdata <= APB_DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		runs_now = v;
		n_settings++;
	endtask

	// One setting of num_runs: load a small region of rows, then a random mix
	// of writes and steps. A step whose walk would touch an unwritten row is
	// replaced by a write.
	task automatic run_phase(int runs, int n, int span, bit squeeze, bit quiet);
		int               region, ri, idx, off, roll;
		bit               legal;
		logic [IDX_W-1:0] q;
		set_runs(runs);
		calm = quiet;
		region = (runs < REGION_MAX) ? runs : REGION_MAX;
		for (int i = 0; i < region; i++) begin
			load_row(i, pick_val(span), pick_val(span), pick_dest(region, runs));
		end
		for (int k = 0; k < n; k++) begin
			if (squeeze && k == n / 4) hold_req = 1'b1;
			roll = $urandom_range(0, 99);
			ri = $urandom_range(0, region - 1);
			if (roll >= 15 && roll < 40) begin
				// row write, now and then far outside the region
				if ($urandom_range(0, 9) == 0) begin
					ri = $urandom_range(0, RUNS_DEF - 1);
					far_rows.push_back(ri);
				end
				load_row(ri, pick_val(span), pick_val(span), pick_dest(region, runs));
				continue;
			end
			if (roll < 15 && far_rows.size() > 0) begin
				ri = far_rows[$urandom_range(0, far_rows.size() - 1)];
			end
			q = pick_val(span);
			// replay the walk on what has been loaded
			legal = 1'b1;
			idx = plan_dest[ri];
			if (idx < runs_now) begin
				off = plan_head[ri] + q;
				forever begin
					if (!plan_written[idx]) begin
						legal = 1'b0;
						break;
					end
					if (idx + 1 < runs_now && off >= int'(plan_len[idx])) begin
						off -= plan_len[idx];
						idx++;
					end else begin
						break;
					end
				end
			end
			if (legal) begin
				lf_query(ri, q);
			end else begin
				load_row($urandom_range(0, region - 1), pick_val(span), pick_val(span),
					pick_dest(region, runs));
			end
		end
	endtask

	// result side: random pops, plus one long stall on request
	initial begin
		int gap;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) gap = idle_gap();
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				gap--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, num_runs at its reset value of one.
		// Largest offset: head and query both all ones, no walk possible.
		load_row(0, '1, '1, '0);
		lf_query(0, '1);
		lf_query(0, '0);
		// destination beyond the loaded runs, starting from a row past num_runs
		load_row(1, IDX_W'(1), '0, '1);
		lf_query(1, '0);
		// top row of the table
		load_row(RUNS_DEF - 1, IDX_W'(1), IDX_W'(16'h8000), '0);
		lf_query(RUNS_DEF - 1, IDX_W'(16'h1234));

		// Four runs: walk over a zero-length row, stop at the last run.
		set_runs(4);
		load_row(0, IDX_W'(3), IDX_W'(2), IDX_W'(1));
		load_row(1, IDX_W'(1), '0, '0);
		load_row(2, '0, IDX_W'(7), IDX_W'(3));
		load_row(3, IDX_W'(5), '0, IDX_W'(2));
		lf_query(0, IDX_W'(4));
		lf_query(2, '0);
		lf_query(1, '0);
		lf_query(3, '1);
		// destination equal to num_runs
		load_row(3, IDX_W'(5), '0, IDX_W'(4));
		lf_query(3, '0);
		// start above num_runs, large offset walks to the end
		lf_query(RUNS_DEF - 1, '0);

		// Random phases, from one run up to the full table.
		run_phase(1, 150, 65535, 1'b0, 1'b0);
		run_phase(2, 200, 20, 1'b0, 1'b0);
		run_phase(7, 300, 10, 1'b1, 1'b0);
		run_phase($urandom_range(8, REGION_MAX), 300, 50, 1'b0, 1'b1);
		run_phase($urandom_range(REGION_MAX + 1, 5000), 250, 300, 1'b0, 1'b0);
		run_phase(RUNS_DEF, 350, 65535, 1'b0, 1'b0);

		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d row writes and %0d steps over %0d num_runs settings (1 to %0d)",
			n_writes, n_steps, n_settings, RUNS_DEF);
		$display("%0d results compared, %0d with a saturated skip count", checked, saturated);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/mtlf_pkg.sv
rtl/core/mtlf_ram.sv
rtl/core/mtlf_fifo.sv
rtl/core/mtlf_front.sv
rtl/core/mtlf_back.sv
rtl/core/move_table_lf_step.sv
rtl/core/mtlf_chk.sv
dv/move_table_lf_step_check.sv
dv/move_table_lf_step_test.sv
